// ===== sv/wo_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wo_pkg
// Shared constants, tables and types of the wheel odometry integrator.
// ----------------------------------------------------------------------------
package wo_pkg;

    localparam int CORDIC_STEPS_DEF = 24;
    localparam int POS_FRAC_DEF     = 16;

    localparam logic signed [31:0] GAIN_INV    = 32'sd163008219;
    localparam logic [63:0]        RATE_TO_BAM = 64'd11468322295;

    localparam logic        DRIVE_MODE_RST = 1'b0;
    localparam logic [11:0] TRACK_RST      = 12'd1300;
    localparam logic [12:0] WHEELBASE_RST  = 13'd1765;
    localparam logic [6:0]  RATIO_RST      = 7'd18;

    localparam logic signed [23:0] YAW_MAX = 24'sh7FFFFF;
    localparam logic signed [23:0] YAW_MIN = 24'sh800000;

    localparam logic [31:0] ATAN_TAB [32] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
        32'h00000001, 32'h00000000
    };

    typedef enum logic [1:0] {
        REG_DRIVE_MODE = 2'd0,
        REG_TRACK      = 2'd1,
        REG_WHEELBASE  = 2'd2,
        REG_RATIO      = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic               done;
        logic signed [31:0] cos_v;
        logic signed [31:0] sin_v;
    } t_cordic_res;

endpackage

// ===== sv/wo_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wo_mul
// Shared shift-add multiplier, 64 x 64 unsigned, one bit of b per cycle.
// ----------------------------------------------------------------------------
module wo_mul (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [63:0]  i_a,
    input  logic [63:0]  i_b,
    output logic         o_done,
    output logic [127:0] o_prod
);
    logic         r_busy;
    logic         r_done;
    logic [5:0]   r_cnt;
    logic [63:0]  r_a;
    logic [63:0]  r_b;
    logic [127:0] r_acc;
    logic [64:0]  w_sum;

    assign w_sum = {1'b0, r_acc[127:64]} + (r_b[0] ? {1'b0, r_a} : 65'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_b   <= i_b;
            r_acc <= '0;
        end else if (r_busy) begin
            r_acc <= {w_sum, r_acc[63:1]};
            r_b   <= {1'b0, r_b[63:1]};
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;
endmodule

// ===== sv/wo_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wo_div
// Shared restoring divider, 64 / 64 unsigned, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module wo_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_num,
    input  logic [63:0] i_den,
    output logic        o_done,
    output logic [63:0] o_quot
);
    logic        r_busy;
    logic        r_done;
    logic [5:0]  r_cnt;
    logic [63:0] r_num;
    logic [63:0] r_den;
    logic [63:0] r_rem;
    logic [63:0] r_quot;
    logic [64:0] w_sh;
    logic        w_ge;
    logic [64:0] w_diff;

    assign w_sh   = {r_rem, r_num[63]};
    assign w_ge   = (w_sh >= {1'b0, r_den});
    assign w_diff = w_sh - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num  <= i_num;
            r_den  <= i_den;
            r_rem  <= '0;
            r_quot <= '0;
        end else if (r_busy) begin
            r_num  <= {r_num[62:0], 1'b0};
            r_rem  <= w_ge ? w_diff[63:0] : w_sh[63:0];
            r_quot <= {r_quot[62:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
endmodule

// ===== sv/wo_cordic.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wo_cordic
// Iterative rotation-mode CORDIC, one micro-rotation per cycle.
// ----------------------------------------------------------------------------
module wo_cordic #(
    parameter int STEPS = wo_pkg::CORDIC_STEPS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [31:0]         i_angle,
    output wo_pkg::t_cordic_res o_res
);
    import wo_pkg::*;

    localparam int CW = $clog2(STEPS);

    logic               r_busy;
    logic               r_done;
    logic [CW-1:0]      r_i;
    logic signed [31:0] r_x;
    logic signed [31:0] r_y;
    logic signed [33:0] r_z;
    logic               w_fold;
    logic [31:0]        w_ang;
    logic signed [33:0] w_atan;

    assign w_fold = (i_angle[31:30] == 2'b01) || (i_angle[31:30] == 2'b10);
    assign w_ang  = w_fold ? (i_angle ^ 32'h8000_0000) : i_angle;
    assign w_atan = $signed({2'b00, ATAN_TAB[5'(r_i)]});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_i    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_i    <= '0;
            end else if (r_busy) begin
                r_i <= r_i + 1'b1;
                if (r_i == CW'(STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x <= w_fold ? -GAIN_INV : GAIN_INV;
            r_y <= '0;
            r_z <= $signed({{2{w_ang[31]}}, w_ang});
        end else if (r_busy) begin
            if (!r_z[33]) begin
                r_x <= r_x - (r_y >>> r_i);
                r_y <= r_y + (r_x >>> r_i);
                r_z <= r_z - w_atan;
            end else begin
                r_x <= r_x + (r_y >>> r_i);
                r_y <= r_y - (r_x >>> r_i);
                r_z <= r_z + w_atan;
            end
        end
    end

    assign o_res.done  = r_done;
    assign o_res.cos_v = r_x;
    assign o_res.sin_v = r_y;
endmodule

// ===== sv/wheel_odometry_integrator_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wheel_odometry_integrator_core
// Dead-reckoning pose integrator with differential or Ackermann kinematics.
// ----------------------------------------------------------------------------
// The input channel takes one word per sample or set-position command,
// accepted when i_in_valid is high and o_in_stall is low. A sample yields
// one pose word on the output channel, a set command yields none and the
// block stays idle. A sample runs through a sequencer that shares one
// 64-bit shift-add multiplier, one 64-bit restoring divider and one
// CORDIC. o_in_stall is high while a sample is in work. The pose sits in
// an output register; when the receiver stalls, the next sample may be
// taken and worked, and it waits at the end until the output register is
// free. Reset clears the pose, heading and previous timestamp and loads the
// register defaults. Registers are written through the APB port; the user
// must write them only while the block is idle, which the block itself
// does not enforce.
// ----------------------------------------------------------------------------
module wheel_odometry_integrator_core #(
    parameter int CORDIC_STEPS           = wo_pkg::CORDIC_STEPS_DEF,
    parameter int POSITION_FRACTION_BITS = wo_pkg::POS_FRAC_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_command,
    input  logic signed [15:0] i_speed_right,
    input  logic signed [15:0] i_speed_left,
    input  logic signed [15:0] i_steer_angle,
    input  logic [31:0]        i_timestamp_us,
    input  logic signed [15:0] i_preset_x_m,
    input  logic signed [15:0] i_preset_y_m,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [31:0] o_pose_x,
    output logic signed [31:0] o_pose_y,
    output logic [31:0]        o_heading,
    output logic signed [15:0] o_linear_speed,
    output logic signed [23:0] o_yaw_rate,
    output logic [31:0]        o_stamp_out,
    output logic               o_mode_used,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import wo_pkg::*;

    localparam logic [63:0] POS_DEN  = (64'd1000000 << 22) >> POSITION_FRACTION_BITS;
    localparam logic [63:0] POS_HALF = POS_DEN >> 1;

    // reciprocal of the position divisor, exact for numerators below 2^62
    localparam int           POS_K     = 62 + $clog2(POS_DEN);
    localparam logic [127:0] POS_RCP_W = ((128'd1 << POS_K) + {64'd0, POS_DEN} - 128'd1)
                                         / {64'd0, POS_DEN};
    localparam logic [63:0]  POS_RECIP = POS_RCP_W[63:0];

    typedef enum logic [14:0] {
        ST_IDLE = 15'b000000000000001,
        ST_YMD  = 15'b000000000000010,
        ST_PDIV = 15'b000000000000100,
        ST_COR1 = 15'b000000000001000,
        ST_AM1  = 15'b000000000010000,
        ST_AM2  = 15'b000000000100000,
        ST_AM3  = 15'b000000001000000,
        ST_YDIV = 15'b000000010000000,
        ST_HM1  = 15'b000000100000000,
        ST_HM2  = 15'b000001000000000,
        ST_COR2 = 15'b000010000000000,
        ST_MX   = 15'b000100000000000,
        ST_MXT  = 15'b001000000000000,
        ST_DPOS = 15'b010000000000000,
        ST_OUT  = 15'b100000000000000
    } t_state;

    function automatic logic signed [23:0] sat_yaw(input logic [63:0] q, input logic neg);
        logic signed [23:0] res;
        if (neg) begin
            res = (q > 64'd8388608) ? YAW_MIN : -$signed(q[23:0]);
        end else begin
            res = (q > 64'd8388607) ? YAW_MAX : $signed(q[23:0]);
        end
        return res;
    endfunction

    t_state             r_state, n_state;
    logic               r_launched, n_launched;
    logic signed [15:0] r_sr, n_sr;
    logic signed [15:0] r_sl, n_sl;
    logic signed [15:0] r_steer, n_steer;
    logic [31:0]        r_ts, n_ts;
    logic [31:0]        r_dt, n_dt;
    logic [31:0]        r_prev, n_prev;
    logic [31:0]        r_pos_x, n_pos_x;
    logic [31:0]        r_pos_y, n_pos_y;
    logic [31:0]        r_head, n_head;
    logic [31:0]        r_mid, n_mid;
    logic [63:0]        r_num, n_num;
    logic               r_num_neg, n_num_neg;
    logic [63:0]        r_den, n_den;
    logic               r_den_neg, n_den_neg;
    logic [63:0]        r_prod, n_prod;
    logic signed [23:0] r_yaw, n_yaw;
    logic signed [63:0] r_m, n_m;
    logic               r_axis, n_axis;
    logic               r_mode, n_mode;

    logic               r_out_valid, n_out_valid;
    logic [31:0]        r_out_x, n_out_x;
    logic [31:0]        r_out_y, n_out_y;
    logic [31:0]        r_out_head, n_out_head;
    logic [15:0]        r_out_lin, n_out_lin;
    logic [23:0]        r_out_yaw, n_out_yaw;
    logic [31:0]        r_out_ts, n_out_ts;
    logic               r_out_mode, n_out_mode;

    logic               r_drive_mode;
    logic [11:0]        r_track;
    logic [12:0]        r_wheelbase;
    logic [6:0]         r_ratio;

    logic               mul_start;
    logic [63:0]        mul_a;
    logic [63:0]        mul_b;
    logic               mul_done;
    logic [127:0]       mul_prod;
    logic               div_start;
    logic [63:0]        div_num;
    logic [63:0]        div_den;
    logic               div_done;
    logic [63:0]        div_quot;
    logic               cor_start;
    logic [31:0]        cor_angle;
    t_cordic_res        cor_res;

    logic signed [16:0] w_vsum;
    logic signed [16:0] w_diff;
    logic [16:0]        w_vmag;
    logic [16:0]        w_dmag;
    logic [16:0]        w_smag17;
    logic [31:0]        w_cmag;
    logic [31:0]        w_snmag;
    logic [6:0]         w_ratio;
    logic [20:0]        w_dd;
    logic [23:0]        w_yawmag;
    logic [63:0]        w_mmag;

    assign w_vsum   = 17'(r_sr) + 17'(r_sl);
    assign w_diff   = 17'(r_sr) - 17'(r_sl);
    assign w_vmag   = w_vsum[16] ? 17'(-w_vsum) : 17'(w_vsum);
    assign w_dmag   = w_diff[16] ? 17'(-w_diff) : 17'(w_diff);
    assign w_smag17 = r_steer[15] ? 17'(-17'(r_steer)) : 17'(r_steer);
    assign w_cmag   = cor_res.cos_v[31] ? 32'(-cor_res.cos_v) : 32'(cor_res.cos_v);
    assign w_snmag  = cor_res.sin_v[31] ? 32'(-cor_res.sin_v) : 32'(cor_res.sin_v);
    assign w_ratio  = (r_ratio == 7'd0) ? 7'd1 : r_ratio;
    assign w_dd     = 21'(w_ratio) * 21'd11520;
    assign w_yawmag = r_yaw[23] ? 24'(-r_yaw) : 24'(r_yaw);
    assign w_mmag   = r_m[63] ? 64'(-r_m) : 64'(r_m);

    wo_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    wo_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    wo_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cor_start),
        .i_angle (cor_angle),
        .o_res   (cor_res)
    );

    // register file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drive_mode <= DRIVE_MODE_RST;
            r_track      <= TRACK_RST;
            r_wheelbase  <= WHEELBASE_RST;
            r_ratio      <= RATIO_RST;
        end else if (psel && penable && pwrite) begin
            unique case (t_reg_idx'(paddr[3:2]))
                REG_DRIVE_MODE: r_drive_mode <= pwdata[0];
                REG_TRACK:      r_track      <= pwdata[11:0];
                REG_WHEELBASE:  r_wheelbase  <= pwdata[12:0];
                REG_RATIO:      r_ratio      <= pwdata[6:0];
            endcase
        end
    end

    always_comb begin
        unique case (t_reg_idx'(paddr[3:2]))
            REG_DRIVE_MODE: prdata = {31'd0, r_drive_mode};
            REG_TRACK:      prdata = {20'd0, r_track};
            REG_WHEELBASE:  prdata = {19'd0, r_wheelbase};
            REG_RATIO:      prdata = {25'd0, r_ratio};
        endcase
    end

    assign pready = 1'b1;

    // sequencer
    always_comb begin
        logic [44:0]        t45;
        logic [32:0]        r33;
        logic [32:0]        d33;
        logic [63:0]        ps;
        logic [63:0]        ts64;
        logic [31:0]        delta;
        logic               numnz;
        logic               mneg;
        logic [31:0]        qa32;
        logic [127:0]       pq;

        t45   = '0;
        r33   = '0;
        d33   = '0;
        ps    = '0;
        ts64  = '0;
        delta = '0;
        numnz = (r_num != 64'd0);
        mneg  = 1'b0;
        qa32  = '0;
        pq    = '0;

        n_state     = r_state;
        n_launched  = r_launched;
        n_sr        = r_sr;
        n_sl        = r_sl;
        n_steer     = r_steer;
        n_ts        = r_ts;
        n_dt        = r_dt;
        n_prev      = r_prev;
        n_pos_x     = r_pos_x;
        n_pos_y     = r_pos_y;
        n_head      = r_head;
        n_mid       = r_mid;
        n_num       = r_num;
        n_num_neg   = r_num_neg;
        n_den       = r_den;
        n_den_neg   = r_den_neg;
        n_prod      = r_prod;
        n_yaw       = r_yaw;
        n_m         = r_m;
        n_axis      = r_axis;
        n_mode      = r_mode;
        n_out_valid = r_out_valid;
        n_out_x     = r_out_x;
        n_out_y     = r_out_y;
        n_out_head  = r_out_head;
        n_out_lin   = r_out_lin;
        n_out_yaw   = r_out_yaw;
        n_out_ts    = r_out_ts;
        n_out_mode  = r_out_mode;

        mul_start = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        div_start = 1'b0;
        div_num   = '0;
        div_den   = 64'd1;
        cor_start = 1'b0;
        cor_angle = r_mid;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    if (i_command) begin
                        n_pos_x = {{16{i_preset_x_m[15]}}, i_preset_x_m}
                                  << POSITION_FRACTION_BITS;
                        n_pos_y = {{16{i_preset_y_m[15]}}, i_preset_y_m}
                                  << POSITION_FRACTION_BITS;
                    end else begin
                        n_sr       = i_speed_right;
                        n_sl       = i_speed_left;
                        n_steer    = i_steer_angle;
                        n_ts       = i_timestamp_us;
                        n_dt       = i_timestamp_us - r_prev;
                        n_prev     = i_timestamp_us;
                        n_mode     = r_drive_mode;
                        n_launched = 1'b0;
                        n_state    = r_drive_mode ? ST_PDIV : ST_YMD;
                    end
                end
            end
            ST_YMD: begin
                mul_a = 64'(w_dmag);
                mul_b = 64'd256000;
                if (!r_launched) begin
                    mul_start  = 1'b1;
                    n_launched = 1'b1;
                end else if (mul_done) begin
                    n_num      = mul_prod[63:0];
                    n_num_neg  = w_diff[16];
                    n_den      = 64'(r_track);
                    n_den_neg  = 1'b0;
                    n_launched = 1'b0;
                    n_state    = ST_YDIV;
                end
            end
            ST_PDIV: begin
                div_num = {15'd0, w_smag17, 32'd0} + 64'(w_dd >> 1);
                div_den = 64'(w_dd);
                if (!r_launched) begin
                    div_start  = 1'b1;
                    n_launched = 1'b1;
                end else if (div_done) begin
                    qa32       = div_quot[31:0];
                    n_mid      = r_steer[15] ? -qa32 : qa32;
                    n_launched = 1'b0;
                    n_state    = ST_COR1;
                end
            end
            ST_COR1: begin
                if (!r_launched) begin
                    cor_start  = 1'b1;
                    n_launched = 1'b1;
                end else if (cor_res.done) begin
                    n_launched = 1'b0;
                    n_state    = ST_AM1;
                end
            end
            ST_AM1: begin
                mul_a = 64'(w_vmag);
                mul_b = 64'd128000;
                if (!r_launched) begin
                    mul_start  = 1'b1;
                    n_launched = 1'b1;
                end else if (mul_done) begin
                    n_prod     = mul_prod[63:0];
                    n_launched = 1'b0;
                    n_state    = ST_AM2;
                end
            end
            ST_AM2: begin
                mul_a = r_prod;
                mul_b = 64'(w_snmag);
                if (!r_launched) begin
                    mul_start  = 1'b1;
                    n_launched = 1'b1;
                end else if (mul_done) begin
                    n_num      = mul_prod[63:0];
                    n_num_neg  = w_vsum[16] ^ cor_res.sin_v[31];
                    n_launched = 1'b0;
                    n_state    = ST_AM3;
                end
            end
            ST_AM3: begin
                mul_a = 64'(r_wheelbase);
                mul_b = 64'(w_cmag);
                if (!r_launched) begin
                    mul_start  = 1'b1;
                    n_launched = 1'b1;
                end else if (mul_done) begin
                    n_den      = mul_prod[63:0];
                    n_den_neg  = cor_res.cos_v[31];
                    n_launched = 1'b0;
                    n_state    = ST_YDIV;
                end
            end
            ST_YDIV: begin
                div_num = r_num + (r_den >> 1);
                div_den = r_den;
                if (r_den == 64'd0) begin
                    n_yaw   = !numnz ? 24'sd0 : (r_num_neg ? YAW_MIN : YAW_MAX);
                    n_state = ST_HM1;
                end else if (!r_launched) begin
                    div_start  = 1'b1;
                    n_launched = 1'b1;
                end else if (div_done) begin
                    n_yaw      = sat_yaw(div_quot, (r_num_neg && numnz) ^ r_den_neg);
                    n_launched = 1'b0;
                    n_state    = ST_HM1;
                end
            end
            ST_HM1: begin
                mul_a = 64'(w_yawmag);
                mul_b = 64'(r_dt);
                if (!r_launched) begin
                    mul_start  = 1'b1;
                    n_launched = 1'b1;
                end else if (mul_done) begin
                    n_prod     = mul_prod[63:0];
                    n_launched = 1'b0;
                    n_state    = ST_HM2;
                end
            end
            ST_HM2: begin
                mul_a = r_prod;
                mul_b = RATE_TO_BAM;
                if (!r_launched) begin
                    mul_start  = 1'b1;
                    n_launched = 1'b1;
                end else if (mul_done) begin
                    t45        = mul_prod[72:28] + 45'd2048;
                    r33        = t45[44:12];
                    d33        = r_yaw[23] ? -r33 : r33;
                    n_mid      = r_head + d33[32:1];
                    n_head     = r_head + d33[31:0];
                    n_launched = 1'b0;
                    n_state    = ST_COR2;
                end
            end
            ST_COR2: begin
                if (!r_launched) begin
                    cor_start  = 1'b1;
                    n_launched = 1'b1;
                end else if (cor_res.done) begin
                    n_axis     = 1'b0;
                    n_launched = 1'b0;
                    n_state    = ST_MX;
                end
            end
            ST_MX: begin
                mul_a = 64'(w_vmag);
                mul_b = r_axis ? 64'(w_snmag) : 64'(w_cmag);
                if (!r_launched) begin
                    mul_start  = 1'b1;
                    n_launched = 1'b1;
                end else if (mul_done) begin
                    mneg       = w_vsum[16] ^ (r_axis ? cor_res.sin_v[31]
                                                      : cor_res.cos_v[31]);
                    ps         = mneg ? -mul_prod[63:0] : mul_prod[63:0];
                    ts64       = ps + 64'd16384;
                    n_m        = $signed(ts64) >>> 15;
                    n_launched = 1'b0;
                    n_state    = ST_MXT;
                end
            end
            ST_MXT: begin
                mul_a = w_mmag;
                mul_b = 64'(r_dt);
                if (!r_launched) begin
                    mul_start  = 1'b1;
                    n_launched = 1'b1;
                end else if (mul_done) begin
                    n_prod     = mul_prod[63:0];
                    n_launched = 1'b0;
                    n_state    = ST_DPOS;
                end
            end
            ST_DPOS: begin
                mul_a = r_prod + POS_HALF;
                mul_b = POS_RECIP;
                if (!r_launched) begin
                    mul_start  = 1'b1;
                    n_launched = 1'b1;
                end else if (mul_done) begin
                    pq         = mul_prod >> POS_K;
                    delta      = r_m[63] ? -pq[31:0] : pq[31:0];
                    n_launched = 1'b0;
                    if (r_axis) begin
                        n_pos_y = r_pos_y + delta;
                        n_state = ST_OUT;
                    end else begin
                        n_pos_x = r_pos_x + delta;
                        n_axis  = 1'b1;
                        n_state = ST_MX;
                    end
                end
            end
            ST_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_out_x     = r_pos_x;
                    n_out_y     = r_pos_y;
                    n_out_head  = r_head;
                    n_out_lin   = w_vsum[16:1];
                    n_out_yaw   = r_yaw;
                    n_out_ts    = r_ts;
                    n_out_mode  = r_mode;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_launched  <= 1'b0;
            r_out_valid <= 1'b0;
            r_prev      <= '0;
            r_pos_x     <= '0;
            r_pos_y     <= '0;
            r_head      <= '0;
        end else begin
            r_state     <= n_state;
            r_launched  <= n_launched;
            r_out_valid <= n_out_valid;
            r_prev      <= n_prev;
            r_pos_x     <= n_pos_x;
            r_pos_y     <= n_pos_y;
            r_head      <= n_head;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sr       <= n_sr;
        r_sl       <= n_sl;
        r_steer    <= n_steer;
        r_ts       <= n_ts;
        r_dt       <= n_dt;
        r_mid      <= n_mid;
        r_num      <= n_num;
        r_num_neg  <= n_num_neg;
        r_den      <= n_den;
        r_den_neg  <= n_den_neg;
        r_prod     <= n_prod;
        r_yaw      <= n_yaw;
        r_m        <= n_m;
        r_axis     <= n_axis;
        r_mode     <= n_mode;
        r_out_x    <= n_out_x;
        r_out_y    <= n_out_y;
        r_out_head <= n_out_head;
        r_out_lin  <= n_out_lin;
        r_out_yaw  <= n_out_yaw;
        r_out_ts   <= n_out_ts;
        r_out_mode <= n_out_mode;
    end

    assign o_in_stall     = (r_state != ST_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_pose_x       = r_out_x;
    assign o_pose_y       = r_out_y;
    assign o_heading      = r_out_head;
    assign o_linear_speed = r_out_lin;
    assign o_yaw_rate     = r_out_yaw;
    assign o_stamp_out    = r_out_ts;
    assign o_mode_used    = r_out_mode;
endmodule
